// ===== rtl/core/lqe_pkg.sv =====
// ----------------------------------------------------------------------------
// lqe_pkg
// shared widths, types and helpers for the line to quad expander
// ----------------------------------------------------------------------------
package lqe_pkg;

    // field widths
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int CFG_WIDTH   = 31;
    localparam int RGBA_WIDTH  = 64;

    // derived widths
    localparam int MAG_W   = COORD_WIDTH + 1;
    localparam int POS_W   = $clog2(MAG_W);
    localparam int SQ_W    = 2 * CFG_WIDTH;
    localparam int HW      = SQ_W - FRAC_BITS;
    localparam int NORM_W  = 30;
    localparam int NORM_TOP = NORM_W - 1;
    localparam int UQ_W    = NORM_W + 1;
    localparam int HH_W    = HW - NORM_W;
    localparam int PH_W    = HH_W + UQ_W;
    localparam int PL_W    = NORM_W + UQ_W;
    localparam int PW      = HW + 1;
    localparam int SUM_W   = ((COORD_WIDTH > PW) ? COORD_WIDTH : PW) + 1;

    // stream widths
    localparam int IN_BITS  = 6 * COORD_WIDTH + CFG_WIDTH + 2 * RGBA_WIDTH;
    localparam int IN_DW    = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 3 * COORD_WIDTH + RGBA_WIDTH;
    localparam int OUT_DW   = ((OUT_BITS + 7) / 8) * 8;

    // rounding constants
    localparam logic [SQ_W-1:0] H_ROUND   = SQ_W'(64'd1 << (FRAC_BITS - 1));
    localparam logic [63:0]     MAG_LIMIT = (64'd1 << CFG_WIDTH) - 64'd1;
    localparam logic [PL_W:0]   U_ROUND   = (PL_W + 1)'(64'd1 << (NORM_W - 1));

    // pipeline shape of the iterative units
    localparam int SQ_STAGES  = 8;
    localparam int SQ_STEPS   = 4;
    localparam int DIV_STAGES = 8;
    localparam int DIV_STEPS  = 4;

    // configuration register indexes
    localparam logic REG_LENGTH_EPSILON  = 1'b0;
    localparam logic REG_THICKNESS_SCALE = 1'b1;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [RGBA_WIDTH-1:0]         rgba_t;
    typedef logic [CFG_WIDTH-1:0]          cfgval_t;

    // one input segment
    typedef struct packed {
        coord_t  start_x;
        coord_t  start_y;
        coord_t  start_z;
        coord_t  end_x;
        coord_t  end_y;
        coord_t  end_z;
        cfgval_t width;
        rgba_t   head_rgba;
        rgba_t   tail_rgba;
    } seg_t;

    // values that ride alongside the offset computation
    typedef struct packed {
        coord_t          sx;
        coord_t          sy;
        coord_t          sz;
        coord_t          ex;
        coord_t          ey;
        coord_t          ez;
        rgba_t           head;
        rgba_t           tail;
        logic [HW-1:0]   h;
        logic            keep;
        logic            zero;
        logic            neg_z;
        logic            pos_x;
    } side_t;

    typedef struct packed {
        side_t             side;
        logic [NORM_W-1:0] na;
        logic [NORM_W-1:0] nb;
        logic [63:0]       sq;
    } sqrt_in_t;

    typedef struct packed {
        side_t             side;
        logic [NORM_W-1:0] na;
        logic [NORM_W-1:0] nb;
        logic [UQ_W-1:0]   root;
    } div_in_t;

    typedef struct packed {
        side_t           side;
        logic [UQ_W-1:0] ua;
        logic [UQ_W-1:0] ub;
    } emit_in_t;

    // clamp a wide signed sum into the coordinate range
    function automatic coord_t sat_coord(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-COORD_WIDTH:0] top;
        coord_t res;
        top = v[SUM_W-1:COORD_WIDTH-1];
        if ((top == '0) || (top == '1)) begin
            res = v[COORD_WIDTH-1:0];
        end else if (v[SUM_W-1]) begin
            res = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            res = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/lqe_setup.sv =====
// ----------------------------------------------------------------------------
// lqe_setup
// difference, length test, half width and normalisation of the side vector
// ----------------------------------------------------------------------------
module lqe_setup
    import lqe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     adv,
    input  logic     in_valid,
    input  seg_t     in_seg,
    input  cfgval_t  length_epsilon,
    input  cfgval_t  thickness_scale,
    output logic     out_valid,
    output sqrt_in_t out_item
);

    typedef struct packed {
        seg_t                     seg;
        logic signed [MAG_W-1:0]  dx;
        logic signed [MAG_W-1:0]  dz;
        logic [SQ_W-1:0]          hprod;
        logic signed [MAG_W-1:0]  dy;
    } st1_t;

    typedef struct packed {
        seg_t             seg;
        logic [MAG_W-1:0] a;
        logic [MAG_W-1:0] b;
        logic [SQ_W-1:0]  sqx;
        logic [SQ_W-1:0]  sqy;
        logic [SQ_W-1:0]  sqz;
        logic [SQ_W-1:0]  eps2;
        logic             in_range;
        logic [HW-1:0]    h;
        logic             neg_z;
        logic             pos_x;
    } st2_t;

    typedef struct packed {
        seg_t             seg;
        logic [MAG_W-1:0] a;
        logic [MAG_W-1:0] b;
        logic [POS_W-1:0] pos;
        logic             zero;
        logic             keep;
        logic [HW-1:0]    h;
        logic             neg_z;
        logic             pos_x;
    } st3_t;

    typedef struct packed {
        side_t             side;
        logic [NORM_W-1:0] na;
        logic [NORM_W-1:0] nb;
    } st4_t;

    typedef struct packed {
        side_t               side;
        logic [NORM_W-1:0]   na;
        logic [NORM_W-1:0]   nb;
        logic [2*NORM_W-1:0] sqa;
        logic [2*NORM_W-1:0] sqb;
    } st5_t;

    st1_t     st1_next, st1_reg;
    st2_t     st2_next, st2_reg;
    st3_t     st3_next, st3_reg;
    st4_t     st4_next, st4_reg;
    st5_t     st5_next, st5_reg;
    sqrt_in_t st6_next, st6_reg;
    logic [5:0] vld_reg;

    // stage 1: exact difference and width product
    always_comb
    begin
        st1_next.seg   = in_seg;
        st1_next.dx    = MAG_W'(in_seg.end_x) - MAG_W'(in_seg.start_x);
        st1_next.dy    = MAG_W'(in_seg.end_y) - MAG_W'(in_seg.start_y);
        st1_next.dz    = MAG_W'(in_seg.end_z) - MAG_W'(in_seg.start_z);
        st1_next.hprod = SQ_W'(in_seg.width) * SQ_W'(thickness_scale);
    end

    // stage 2: magnitudes, squares and rounded half width
    always_comb
    begin
        logic [MAG_W-1:0] mx;
        logic [MAG_W-1:0] my;
        logic [MAG_W-1:0] mz;
        mx = st1_reg.dx[MAG_W-1] ? MAG_W'(-st1_reg.dx) : MAG_W'(st1_reg.dx);
        my = st1_reg.dy[MAG_W-1] ? MAG_W'(-st1_reg.dy) : MAG_W'(st1_reg.dy);
        mz = st1_reg.dz[MAG_W-1] ? MAG_W'(-st1_reg.dz) : MAG_W'(st1_reg.dz);
        st2_next.seg   = st1_reg.seg;
        st2_next.a     = mz;
        st2_next.b     = mx;
        st2_next.sqx   = SQ_W'(CFG_WIDTH'(mx)) * SQ_W'(CFG_WIDTH'(mx));
        st2_next.sqy   = SQ_W'(CFG_WIDTH'(my)) * SQ_W'(CFG_WIDTH'(my));
        st2_next.sqz   = SQ_W'(CFG_WIDTH'(mz)) * SQ_W'(CFG_WIDTH'(mz));
        st2_next.eps2  = SQ_W'(length_epsilon) * SQ_W'(length_epsilon);
        st2_next.in_range = (64'(mx) <= MAG_LIMIT) && (64'(my) <= MAG_LIMIT)
                            && (64'(mz) <= MAG_LIMIT);
        st2_next.h     = HW'((st1_reg.hprod + H_ROUND) >> FRAC_BITS);
        st2_next.neg_z = st1_reg.dz[MAG_W-1];
        st2_next.pos_x = !st1_reg.dx[MAG_W-1] && (st1_reg.dx != '0);
    end

    // stage 3: length test and leading one of the larger component
    always_comb
    begin
        logic [63:0]      ss;
        logic [MAG_W-1:0] m;
        ss = 64'(st2_reg.sqx) + 64'(st2_reg.sqy) + 64'(st2_reg.sqz);
        m  = (st2_reg.a > st2_reg.b) ? st2_reg.a : st2_reg.b;
        st3_next.pos = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (m[i])
            begin
                st3_next.pos = POS_W'(i);
            end
        end
        st3_next.seg   = st2_reg.seg;
        st3_next.a     = st2_reg.a;
        st3_next.b     = st2_reg.b;
        st3_next.zero  = (m == '0);
        st3_next.keep  = !(st2_reg.in_range && (ss < 64'(st2_reg.eps2)));
        st3_next.h     = st2_reg.h;
        st3_next.neg_z = st2_reg.neg_z;
        st3_next.pos_x = st2_reg.pos_x;
    end

    // stage 4: shift both components so the larger sits just under the top
    always_comb
    begin
        st4_next.side.sx    = st3_reg.seg.start_x;
        st4_next.side.sy    = st3_reg.seg.start_y;
        st4_next.side.sz    = st3_reg.seg.start_z;
        st4_next.side.ex    = st3_reg.seg.end_x;
        st4_next.side.ey    = st3_reg.seg.end_y;
        st4_next.side.ez    = st3_reg.seg.end_z;
        st4_next.side.head  = st3_reg.seg.head_rgba;
        st4_next.side.tail  = st3_reg.seg.tail_rgba;
        st4_next.side.h     = st3_reg.h;
        st4_next.side.keep  = st3_reg.keep;
        st4_next.side.zero  = st3_reg.zero;
        st4_next.side.neg_z = st3_reg.neg_z;
        st4_next.side.pos_x = st3_reg.pos_x;
        if (st3_reg.pos >= POS_W'(NORM_TOP))
        begin
            st4_next.na = NORM_W'(st3_reg.a >> (st3_reg.pos - POS_W'(NORM_TOP)));
            st4_next.nb = NORM_W'(st3_reg.b >> (st3_reg.pos - POS_W'(NORM_TOP)));
        end
        else
        begin
            st4_next.na = NORM_W'(64'(st3_reg.a) << (POS_W'(NORM_TOP) - st3_reg.pos));
            st4_next.nb = NORM_W'(64'(st3_reg.b) << (POS_W'(NORM_TOP) - st3_reg.pos));
        end
    end

    // stage 5: squares of the normalised components
    always_comb
    begin
        st5_next.side = st4_reg.side;
        st5_next.na   = st4_reg.na;
        st5_next.nb   = st4_reg.nb;
        st5_next.sqa  = (2*NORM_W)'(st4_reg.na) * (2*NORM_W)'(st4_reg.na);
        st5_next.sqb  = (2*NORM_W)'(st4_reg.nb) * (2*NORM_W)'(st4_reg.nb);
    end

    // stage 6: radicand for the root
    always_comb
    begin
        st6_next.side = st5_reg.side;
        st6_next.na   = st5_reg.na;
        st6_next.nb   = st5_reg.nb;
        st6_next.sq   = 64'(st5_reg.sqa) + 64'(st5_reg.sqb);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st1_reg <= st1_next;
            st2_reg <= st2_next;
            st3_reg <= st3_next;
            st4_reg <= st4_next;
            st5_reg <= st5_next;
            st6_reg <= st6_next;
        end
    end

    assign out_valid = vld_reg[5];
    assign out_item  = st6_reg;

endmodule

// ===== rtl/core/lqe_isqrt.sv =====
// ----------------------------------------------------------------------------
// lqe_isqrt
// pipelined integer square root, two radicand bits per step
// ----------------------------------------------------------------------------
module lqe_isqrt
    import lqe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     adv,
    input  logic     in_valid,
    input  sqrt_in_t in_item,
    output logic     out_valid,
    output div_in_t  out_item
);

    typedef struct packed {
        side_t             side;
        logic [NORM_W-1:0] na;
        logic [NORM_W-1:0] nb;
        logic [63:0]       rad;
        logic [35:0]       rem;
        logic [31:0]       root;
    } sq_stage_t;

    sq_stage_t first_stage;
    sq_stage_t stg_in   [SQ_STAGES];
    sq_stage_t stg_next [SQ_STAGES];
    sq_stage_t stg_reg  [SQ_STAGES];
    logic [SQ_STAGES-1:0] vld_reg;

    // load the radicand
    always_comb
    begin
        first_stage.side = in_item.side;
        first_stage.na   = in_item.na;
        first_stage.nb   = in_item.nb;
        first_stage.rad  = in_item.sq;
        first_stage.rem  = '0;
        first_stage.root = '0;
    end

    for (genvar k = 0; k < SQ_STAGES; k++)
    begin : g_stage
        if (k == 0)
        begin : g_first
            assign stg_in[k] = first_stage;
        end
        else
        begin : g_chain
            assign stg_in[k] = stg_reg[k-1];
        end

        // restoring root steps
        always_comb
        begin
            sq_stage_t   s;
            logic [35:0] r;
            logic [35:0] t;
            s = stg_in[k];
            for (int j = 0; j < SQ_STEPS; j++)
            begin
                r = {s.rem[33:0], s.rad[63:62]};
                t = {2'b00, s.root, 2'b01};
                if (r >= t)
                begin
                    s.rem  = r - t;
                    s.root = {s.root[30:0], 1'b1};
                end
                else
                begin
                    s.rem  = r;
                    s.root = {s.root[30:0], 1'b0};
                end
                s.rad = {s.rad[61:0], 2'b00};
            end
            stg_next[k] = s;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[SQ_STAGES-2:0], in_valid};
        end
    end

    assign out_valid     = vld_reg[SQ_STAGES-1];
    assign out_item.side = stg_reg[SQ_STAGES-1].side;
    assign out_item.na   = stg_reg[SQ_STAGES-1].na;
    assign out_item.nb   = stg_reg[SQ_STAGES-1].nb;
    assign out_item.root = stg_reg[SQ_STAGES-1].root[UQ_W-1:0];

endmodule

// ===== rtl/core/lqe_div.sv =====
// ----------------------------------------------------------------------------
// lqe_div
// pipelined restoring dividers giving both unit components
// ----------------------------------------------------------------------------
module lqe_div
    import lqe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     adv,
    input  logic     in_valid,
    input  div_in_t  in_item,
    output logic     out_valid,
    output emit_in_t out_item
);

    typedef struct packed {
        side_t           side;
        logic [UQ_W-1:0] dvs;
        logic [31:0]     rem_a;
        logic [31:0]     bits_a;
        logic [31:0]     q_a;
        logic [31:0]     rem_b;
        logic [31:0]     bits_b;
        logic [31:0]     q_b;
    } dv_stage_t;

    dv_stage_t first_stage;
    dv_stage_t stg_in   [DIV_STAGES];
    dv_stage_t stg_next [DIV_STAGES];
    dv_stage_t stg_reg  [DIV_STAGES];
    logic [DIV_STAGES-1:0] vld_reg;

    // numerators with half the divisor added for rounding
    always_comb
    begin
        logic [63:0] num_a;
        logic [63:0] num_b;
        num_a = 64'({in_item.na, {NORM_W{1'b0}}}) + 64'(in_item.root >> 1);
        num_b = 64'({in_item.nb, {NORM_W{1'b0}}}) + 64'(in_item.root >> 1);
        first_stage.side   = in_item.side;
        first_stage.dvs    = in_item.root;
        first_stage.rem_a  = num_a[63:32];
        first_stage.bits_a = num_a[31:0];
        first_stage.q_a    = '0;
        first_stage.rem_b  = num_b[63:32];
        first_stage.bits_b = num_b[31:0];
        first_stage.q_b    = '0;
    end

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        if (k == 0)
        begin : g_first
            assign stg_in[k] = first_stage;
        end
        else
        begin : g_chain
            assign stg_in[k] = stg_reg[k-1];
        end

        // one quotient bit per step in each lane
        always_comb
        begin
            dv_stage_t   s;
            logic [32:0] ra;
            logic [32:0] rb;
            s = stg_in[k];
            for (int j = 0; j < DIV_STEPS; j++)
            begin
                ra = {s.rem_a, s.bits_a[31]};
                rb = {s.rem_b, s.bits_b[31]};
                if (ra >= 33'(s.dvs))
                begin
                    s.rem_a = 32'(ra - 33'(s.dvs));
                    s.q_a   = {s.q_a[30:0], 1'b1};
                end
                else
                begin
                    s.rem_a = ra[31:0];
                    s.q_a   = {s.q_a[30:0], 1'b0};
                end
                if (rb >= 33'(s.dvs))
                begin
                    s.rem_b = 32'(rb - 33'(s.dvs));
                    s.q_b   = {s.q_b[30:0], 1'b1};
                end
                else
                begin
                    s.rem_b = rb[31:0];
                    s.q_b   = {s.q_b[30:0], 1'b0};
                end
                s.bits_a = {s.bits_a[30:0], 1'b0};
                s.bits_b = {s.bits_b[30:0], 1'b0};
            end
            stg_next[k] = s;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[DIV_STAGES-2:0], in_valid};
        end
    end

    assign out_valid     = vld_reg[DIV_STAGES-1];
    assign out_item.side = stg_reg[DIV_STAGES-1].side;
    assign out_item.ua   = stg_reg[DIV_STAGES-1].q_a[UQ_W-1:0];
    assign out_item.ub   = stg_reg[DIV_STAGES-1].q_b[UQ_W-1:0];

endmodule

// ===== rtl/core/lqe_emit.sv =====
// ----------------------------------------------------------------------------
// lqe_emit
// offset scaling, vertex sums and the six beat output sequencer
// ----------------------------------------------------------------------------
module lqe_emit
    import lqe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  emit_in_t         in_item,
    output logic             adv,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_DW-1:0] m_tdata,   // vert_x, vert_y, vert_z, vert_rgba
    output logic             m_tlast
);

    localparam logic [2:0] BEAT_LAST = 3'd5;

    typedef struct packed {
        side_t           side;
        logic [PH_W-1:0] pha;
        logic [PL_W-1:0] pla;
        logic [PH_W-1:0] phb;
        logic [PL_W-1:0] plb;
    } e1_t;

    typedef struct packed {
        side_t                   side;
        logic signed [SUM_W-1:0] ox;
        logic signed [SUM_W-1:0] oz;
    } e2_t;

    typedef struct packed {
        coord_t x0;
        coord_t x1;
        coord_t x2;
        coord_t x3;
        coord_t z0;
        coord_t z1;
        coord_t z2;
        coord_t z3;
        coord_t sy;
        coord_t ey;
        rgba_t  head;
        rgba_t  tail;
        logic   keep;
    } e3_t;

    e1_t  e1_next, e1_reg;
    e2_t  e2_next, e2_reg;
    e3_t  e3_next, e3_reg;
    e3_t  hold_reg;
    logic [2:0] vld_reg;
    logic       busy_reg;
    logic [2:0] beat_reg;
    logic       load;
    coord_t     vx, vy, vz;
    rgba_t      vc;

    // stage 1: half width times unit, split into high and low products
    always_comb
    begin
        logic [HH_W-1:0]   hh;
        logic [NORM_W-1:0] hl;
        hh = in_item.side.h[HW-1:NORM_W];
        hl = in_item.side.h[NORM_W-1:0];
        e1_next.side = in_item.side;
        e1_next.pha  = PH_W'(hh) * PH_W'(in_item.ua);
        e1_next.pla  = PL_W'(hl) * PL_W'(in_item.ua);
        e1_next.phb  = PH_W'(hh) * PH_W'(in_item.ub);
        e1_next.plb  = PL_W'(hl) * PL_W'(in_item.ub);
    end

    // stage 2: round the products and give them their signs
    always_comb
    begin
        logic [PW-1:0] pa;
        logic [PW-1:0] pb;
        pa = PW'(e1_reg.pha) + PW'(((PL_W + 1)'(e1_reg.pla) + U_ROUND) >> NORM_W);
        pb = PW'(e1_reg.phb) + PW'(((PL_W + 1)'(e1_reg.plb) + U_ROUND) >> NORM_W);
        e2_next.side = e1_reg.side;
        if (e1_reg.side.zero)
        begin
            e2_next.ox = '0;
            e2_next.oz = '0;
        end
        else
        begin
            e2_next.ox = e1_reg.side.neg_z ? -$signed(SUM_W'(pa)) : $signed(SUM_W'(pa));
            e2_next.oz = e1_reg.side.pos_x ? -$signed(SUM_W'(pb)) : $signed(SUM_W'(pb));
        end
    end

    // stage 3: the four corners, saturated
    always_comb
    begin
        e3_next.x0   = sat_coord(SUM_W'(e2_reg.side.sx) - e2_reg.ox);
        e3_next.x1   = sat_coord(SUM_W'(e2_reg.side.sx) + e2_reg.ox);
        e3_next.x2   = sat_coord(SUM_W'(e2_reg.side.ex) + e2_reg.ox);
        e3_next.x3   = sat_coord(SUM_W'(e2_reg.side.ex) - e2_reg.ox);
        e3_next.z0   = sat_coord(SUM_W'(e2_reg.side.sz) - e2_reg.oz);
        e3_next.z1   = sat_coord(SUM_W'(e2_reg.side.sz) + e2_reg.oz);
        e3_next.z2   = sat_coord(SUM_W'(e2_reg.side.ez) + e2_reg.oz);
        e3_next.z3   = sat_coord(SUM_W'(e2_reg.side.ez) - e2_reg.oz);
        e3_next.sy   = e2_reg.side.sy;
        e3_next.ey   = e2_reg.side.ey;
        e3_next.head = e2_reg.side.head;
        e3_next.tail = e2_reg.side.tail;
        e3_next.keep = e2_reg.side.keep;
    end

    // sequencer takes a quad when empty or on its final beat
    assign load = !busy_reg || (m_tready && (beat_reg == BEAT_LAST));
    assign adv  = load || !vld_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            busy_reg <= 1'b0;
            beat_reg <= '0;
        end
        else
        begin
            if (adv)
            begin
                vld_reg <= {vld_reg[1:0], in_valid};
            end
            if (busy_reg && m_tready)
            begin
                if (beat_reg == BEAT_LAST)
                begin
                    busy_reg <= 1'b0;
                end
                beat_reg <= beat_reg + 3'd1;
            end
            if (adv && vld_reg[2] && e3_reg.keep)
            begin
                busy_reg <= 1'b1;
                beat_reg <= '0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_reg <= e1_next;
            e2_reg <= e2_next;
            e3_reg <= e3_next;
            if (vld_reg[2] && e3_reg.keep)
            begin
                hold_reg <= e3_reg;
            end
        end
    end

    // vertex order v0 v1 v2, v0 v2 v3
    always_comb
    begin
        case (beat_reg) inside
            3'd0:
            begin
                vx = hold_reg.x0; vy = hold_reg.sy; vz = hold_reg.z0; vc = hold_reg.tail;
            end
            3'd1:
            begin
                vx = hold_reg.x1; vy = hold_reg.sy; vz = hold_reg.z1; vc = hold_reg.tail;
            end
            3'd2, 3'd4:
            begin
                vx = hold_reg.x2; vy = hold_reg.ey; vz = hold_reg.z2; vc = hold_reg.head;
            end
            3'd3:
            begin
                vx = hold_reg.x0; vy = hold_reg.sy; vz = hold_reg.z0; vc = hold_reg.tail;
            end
            default:
            begin
                vx = hold_reg.x3; vy = hold_reg.ey; vz = hold_reg.z3; vc = hold_reg.head;
            end
        endcase
    end

    assign m_tvalid = busy_reg;
    assign m_tdata  = OUT_DW'({vc, vz, vy, vx});
    assign m_tlast  = (beat_reg == BEAT_LAST);

endmodule

// ===== rtl/core/line_to_quad_expander_top.sv =====
// ----------------------------------------------------------------------------
// line_to_quad_expander_top
// expands a 3d segment into a flat ribbon quad sent as six vertices
// ----------------------------------------------------------------------------
// usage
// - s_* takes one segment per beat: both end points, full width and the
//   head and tail colours. m_* gives six vertex beats per segment (two
//   triangles), tlast high on the sixth. segments shorter than the length
//   epsilon give no beats at all.
// - cfg_* writes length_epsilon (index 0) or thickness_scale (index 1) on
//   any edge with cfg_wr_en high; write only while the block is idle.
// - an accepted segment passes 6 setup stages, 8 root stages, 8 divider
//   stages, 3 offset stages and the output register before its first
//   vertex beat.
// - throughput: one vertex beat per cycle while m_tready is high, set by
//   the single output channel. the pipeline takes a segment per cycle
//   while it has room and the next quad is taken on the last beat.
// - reset clears all valid bits and the output sequencer and loads the
//   register defaults (epsilon 1, scale one half).
// - a stalled receiver holds the current beat; the pipeline freezes behind
//   it once its end stage is full and s_tready drops.
// ----------------------------------------------------------------------------
module line_to_quad_expander_top
    import lqe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z, width, head_rgba, tail_rgba
    input  logic [IN_DW-1:0]  s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // vert_x, vert_y, vert_z, vert_rgba
    output logic [OUT_DW-1:0] m_tdata,
    output logic              m_tlast,
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  cfgval_t           cfg_wdata
);

    localparam int OFF_SY = COORD_WIDTH;
    localparam int OFF_SZ = 2 * COORD_WIDTH;
    localparam int OFF_EX = 3 * COORD_WIDTH;
    localparam int OFF_EY = 4 * COORD_WIDTH;
    localparam int OFF_EZ = 5 * COORD_WIDTH;
    localparam int OFF_W  = 6 * COORD_WIDTH;
    localparam int OFF_HD = OFF_W + CFG_WIDTH;
    localparam int OFF_TL = OFF_HD + RGBA_WIDTH;

    cfgval_t  eps_reg;
    cfgval_t  scale_reg;
    seg_t     seg;
    logic     adv;
    logic     su_valid;
    sqrt_in_t su_item;
    logic     sq_valid;
    div_in_t  sq_item;
    logic     dv_valid;
    emit_in_t dv_item;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg   <= CFG_WIDTH'(1);
            scale_reg <= CFG_WIDTH'(32768);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_LENGTH_EPSILON:  eps_reg   <= cfg_wdata;
                REG_THICKNESS_SCALE: scale_reg <= cfg_wdata;
                default:             eps_reg   <= eps_reg;
            endcase
        end
    end

    // unpack the input beat
    always_comb
    begin
        seg.start_x   = s_tdata[0 +: COORD_WIDTH];
        seg.start_y   = s_tdata[OFF_SY +: COORD_WIDTH];
        seg.start_z   = s_tdata[OFF_SZ +: COORD_WIDTH];
        seg.end_x     = s_tdata[OFF_EX +: COORD_WIDTH];
        seg.end_y     = s_tdata[OFF_EY +: COORD_WIDTH];
        seg.end_z     = s_tdata[OFF_EZ +: COORD_WIDTH];
        seg.width     = s_tdata[OFF_W +: CFG_WIDTH];
        seg.head_rgba = s_tdata[OFF_HD +: RGBA_WIDTH];
        seg.tail_rgba = s_tdata[OFF_TL +: RGBA_WIDTH];
    end

    assign s_tready = adv;

    lqe_setup u_setup (
        .clk             (clk),
        .rst_n           (rst_n),
        .adv             (adv),
        .in_valid        (s_tvalid),
        .in_seg          (seg),
        .length_epsilon  (eps_reg),
        .thickness_scale (scale_reg),
        .out_valid       (su_valid),
        .out_item        (su_item)
    );

    lqe_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (su_valid),
        .in_item   (su_item),
        .out_valid (sq_valid),
        .out_item  (sq_item)
    );

    lqe_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sq_valid),
        .in_item   (sq_item),
        .out_valid (dv_valid),
        .out_item  (dv_item)
    );

    lqe_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (dv_valid),
        .in_item  (dv_item),
        .adv      (adv),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
